// ===== rtl/fdmm_pkg.sv =====
// Shared constants, register codes and stage types for the frame difference motion mask.
package fdmm_pkg;

    localparam int FRAME_PIXELS = 65536;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);
    localparam int PIX_W        = 24;
    localparam int PROD_W       = 22;
    localparam int GRAY_SHIFT   = 14;
    localparam int HIST_DEPTH   = 3;
    localparam int PADDR_W      = 5;
    localparam int CFG_IDX_W    = PADDR_W - 2;

    localparam logic [13:0]       GRAY_WB    = 14'd1868;
    localparam logic [13:0]       GRAY_WG    = 14'd9617;
    localparam logic [13:0]       GRAY_WR    = 14'd4899;
    localparam logic [PROD_W-1:0] GRAY_ROUND = PROD_W'(8192);
    localparam logic [7:0]        MARK_ON    = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_USE_PIPELINE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RESTRICT_TO_ZONE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SELECTED_ZONE    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_ADDITIVE         = CFG_IDX_W'(4);

    typedef struct packed {
        logic       use_pipeline;
        logic [7:0] diff_threshold;
        logic       restrict_to_zone;
        logic [7:0] selected_zone;
        logic       additive;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic [7:0]        mask_in;
        logic [7:0]        zone;
        logic              is_static;
    } pix_t;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [7:0]        db;
        logic [7:0]        dg;
        logic [7:0]        dr;
        logic [7:0]        mask_in;
        logic [7:0]        zone;
        logic              is_static;
        logic [7:0]        two_back;
        logic [7:0]        gray_old;
    } s2_t;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [PROD_W-1:0] prod_b;
        logic [PROD_W-1:0] prod_g;
        logic [PROD_W-1:0] prod_r;
        logic [7:0]        mask_in;
        logic [7:0]        zone;
        logic              is_static;
        logic [7:0]        two_back;
        logic [7:0]        gray_old;
    } s3_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } prior_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        one_back;
        logic [7:0]        two_back;
    } mask_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        gray;
    } gray_wr_t;

endpackage

// ===== rtl/frame_difference_motion_mask.sv =====
// Frame difference motion mask with per-pixel frame, gray and mask history stores.
// A pixel passes the input, difference, product and output registers in order.
// Throughput: one pixel per cycle; the four-stage pipeline holds as a whole while
// m_tvalid is high and m_tready low. Each store has one read and one write port.
// Reset: clears configuration, then sweeps all 65536 store entries to zero, one per
// cycle, with s_tready low; configuration writes are taken during the sweep.
module frame_difference_motion_mask import fdmm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // s_tdata: pixel_index[15:0], blue[23:16], green[31:24], red[39:32],
    //          mask_in[47:40], zone_label[55:48]
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [55:0]        s_tdata,
    // s_tuser: static_frame[0]
    input  logic [0:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // m_tdata: mask_out[7:0]
    output logic [7:0]         m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t              cfg_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              s1_valid_reg;
    pix_t              s1_pix_reg;
    pix_t              s1_pix_next;
    logic              en;
    logic              accept;
    logic [CFG_IDX_W-1:0] cfg_idx;

    logic [PIX_W-1:0]  prior_rd;
    logic [7:0]        one_rd;
    logic [7:0]        two_rd;
    logic [7:0]        gray_rd;
    prior_wr_t         prior_wr;
    mask_wr_t          mask_wr;
    gray_wr_t          gray_wr;
    logic              s2_valid;
    s2_t               s2;
    logic              s3_valid;
    s3_t               s3;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_idx)
                REG_USE_PIPELINE:     cfg_reg.use_pipeline     <= pwdata[0];
                REG_DIFF_THRESHOLD:   cfg_reg.diff_threshold   <= pwdata[7:0];
                REG_RESTRICT_TO_ZONE: cfg_reg.restrict_to_zone <= pwdata[0];
                REG_SELECTED_ZONE:    cfg_reg.selected_zone    <= pwdata[7:0];
                REG_ADDITIVE:         cfg_reg.additive         <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_USE_PIPELINE:     prdata = {31'b0, cfg_reg.use_pipeline};
            REG_DIFF_THRESHOLD:   prdata = {24'b0, cfg_reg.diff_threshold};
            REG_RESTRICT_TO_ZONE: prdata = {31'b0, cfg_reg.restrict_to_zone};
            REG_SELECTED_ZONE:    prdata = {24'b0, cfg_reg.selected_zone};
            REG_ADDITIVE:         prdata = {31'b0, cfg_reg.additive};
            default:              prdata = 32'b0;
        endcase
    end

    // Clearing sweep after reset; the counter wraps back to zero at the end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(FRAME_PIXELS - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Advance every stage together whenever the output register is free or drains.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && !clearing_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        s1_pix_next.idx       = s_tdata[ADDR_W-1:0];
        s1_pix_next.blue      = s_tdata[23:16];
        s1_pix_next.green     = s_tdata[31:24];
        s1_pix_next.red       = s_tdata[39:32];
        s1_pix_next.mask_in   = s_tdata[47:40];
        s1_pix_next.zone      = s_tdata[55:48];
        s1_pix_next.is_static = s_tuser[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg <= s1_pix_next;
        end
    end

    fdmm_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_PIXELS)) u_prior_ram (
        .aclk  (aclk),
        .we    (clearing_reg || prior_wr.en),
        .waddr (clearing_reg ? clr_addr_reg : prior_wr.addr),
        .wdata (clearing_reg ? {PIX_W{1'b0}} : prior_wr.data),
        .re    (accept),
        .raddr (s1_pix_next.idx),
        .rdata (prior_rd)
    );

    fdmm_ram #(.WIDTH(8), .DEPTH(FRAME_PIXELS)) u_one_back_ram (
        .aclk  (aclk),
        .we    (clearing_reg || mask_wr.en),
        .waddr (clearing_reg ? clr_addr_reg : mask_wr.addr),
        .wdata (clearing_reg ? 8'h00 : mask_wr.one_back),
        .re    (accept),
        .raddr (s1_pix_next.idx),
        .rdata (one_rd)
    );

    fdmm_ram #(.WIDTH(8), .DEPTH(FRAME_PIXELS)) u_two_back_ram (
        .aclk  (aclk),
        .we    (clearing_reg || mask_wr.en),
        .waddr (clearing_reg ? clr_addr_reg : mask_wr.addr),
        .wdata (clearing_reg ? 8'h00 : mask_wr.two_back),
        .re    (accept),
        .raddr (s1_pix_next.idx),
        .rdata (two_rd)
    );

    fdmm_ram #(.WIDTH(8), .DEPTH(FRAME_PIXELS)) u_gray_ram (
        .aclk  (aclk),
        .we    (clearing_reg || gray_wr.en),
        .waddr (clearing_reg ? clr_addr_reg : gray_wr.addr),
        .wdata (clearing_reg ? 8'h00 : gray_wr.gray),
        .re    (accept),
        .raddr (s1_pix_next.idx),
        .rdata (gray_rd)
    );

    fdmm_diff u_diff (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .s1_valid (s1_valid_reg),
        .s1_pix   (s1_pix_reg),
        .prior_rd (prior_rd),
        .one_rd   (one_rd),
        .two_rd   (two_rd),
        .gray_rd  (gray_rd),
        .cfg      (cfg_reg),
        .prior_wr (prior_wr),
        .mask_wr  (mask_wr),
        .s2_valid (s2_valid),
        .s2       (s2)
    );

    fdmm_gray u_gray (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .s2_valid (s2_valid),
        .s2       (s2),
        .s3_valid (s3_valid),
        .s3       (s3)
    );

    fdmm_mark u_mark (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .s3_valid  (s3_valid),
        .s3        (s3),
        .cfg       (cfg_reg),
        .gray_wr   (gray_wr),
        .out_valid (m_tvalid),
        .out_mask  (m_tdata)
    );

    a_empty_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !(s1_valid_reg || s2_valid || s3_valid || m_tvalid))
        else $error("pipeline holds a pixel during the clearing sweep");

    a_no_item_write_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !(prior_wr.en || mask_wr.en || gray_wr.en))
        else $error("store write from a pixel during the clearing sweep");

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted pixel missing from the first stage");

    a_sweep_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> clr_addr_reg == '0)
        else $error("clearing sweep ended before covering every entry");

endmodule

// ===== rtl/fdmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
module fdmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fdmm_diff.sv =====
// First stage: store forwarding, history and prior-frame writes, per-channel absolute difference.
module fdmm_diff import fdmm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             s1_valid,
    input  pix_t             s1_pix,
    input  logic [PIX_W-1:0] prior_rd,
    input  logic [7:0]       one_rd,
    input  logic [7:0]       two_rd,
    input  logic [7:0]       gray_rd,
    input  cfg_t             cfg,
    output prior_wr_t        prior_wr,
    output mask_wr_t         mask_wr,
    output logic             s2_valid,
    output s2_t              s2
);

    prior_wr_t        prior_fw_reg;
    mask_wr_t         mask_fw_reg;
    logic             s2_valid_reg;
    s2_t              s2_reg;
    s2_t              s2_next;
    logic [PIX_W-1:0] prev;
    logic [7:0]       one_back;
    logic [7:0]       two_back;

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        absdiff8 = (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        // The write issued in the cycle this item was read is not yet in the RAM output.
        prev = (prior_fw_reg.en && prior_fw_reg.addr == s1_pix.idx) ? prior_fw_reg.data
                                                                     : prior_rd;
        if (mask_fw_reg.en && mask_fw_reg.addr == s1_pix.idx) begin
            one_back = mask_fw_reg.one_back;
            two_back = mask_fw_reg.two_back;
        end else begin
            one_back = one_rd;
            two_back = two_rd;
        end

        prior_wr.en   = en && s1_valid && !cfg.use_pipeline && !s1_pix.is_static;
        prior_wr.addr = s1_pix.idx;
        prior_wr.data = {s1_pix.red, s1_pix.green, s1_pix.blue};

        mask_wr.en       = en && s1_valid && cfg.use_pipeline && !s1_pix.is_static;
        mask_wr.addr     = s1_pix.idx;
        mask_wr.one_back = s1_pix.mask_in;
        mask_wr.two_back = one_back;

        s2_next.idx       = s1_pix.idx;
        s2_next.db        = absdiff8(s1_pix.blue,  prev[7:0]);
        s2_next.dg        = absdiff8(s1_pix.green, prev[15:8]);
        s2_next.dr        = absdiff8(s1_pix.red,   prev[23:16]);
        s2_next.mask_in   = s1_pix.mask_in;
        s2_next.zone      = s1_pix.zone;
        s2_next.is_static = s1_pix.is_static;
        s2_next.two_back  = two_back;
        s2_next.gray_old  = gray_rd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_fw_reg.en <= 1'b0;
            mask_fw_reg.en  <= 1'b0;
            s2_valid_reg    <= 1'b0;
        end else if (en) begin
            prior_fw_reg <= prior_wr;
            mask_fw_reg  <= mask_wr;
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s1_valid) begin
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

// ===== rtl/fdmm_gray.sv =====
// Second stage: weight the channel differences for the gray conversion.
module fdmm_gray import fdmm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic s2_valid,
    input  s2_t  s2,
    output logic s3_valid,
    output s3_t  s3
);

    logic s3_valid_reg;
    s3_t  s3_reg;
    s3_t  s3_next;

    always_comb begin
        s3_next.idx       = s2.idx;
        s3_next.prod_b    = PROD_W'(s2.db) * PROD_W'(GRAY_WB);
        s3_next.prod_g    = PROD_W'(s2.dg) * PROD_W'(GRAY_WG);
        s3_next.prod_r    = PROD_W'(s2.dr) * PROD_W'(GRAY_WR);
        s3_next.mask_in   = s2.mask_in;
        s3_next.zone      = s2.zone;
        s3_next.is_static = s2.is_static;
        s3_next.two_back  = s2.two_back;
        s3_next.gray_old  = s2.gray_old;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s2_valid) begin
            s3_reg <= s3_next;
        end
    end

    assign s3_valid = s3_valid_reg;
    assign s3       = s3_reg;

endmodule

// ===== rtl/fdmm_mark.sv =====
// Last stage: gray sum, stored-gray forwarding, threshold, zone gate and mask combine.
module fdmm_mark import fdmm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       s3_valid,
    input  s3_t        s3,
    input  cfg_t       cfg,
    output gray_wr_t   gray_wr,
    output logic       out_valid,
    output logic [7:0] out_mask
);

    gray_wr_t          hist_reg [HIST_DEPTH];
    logic              out_valid_reg;
    logic [7:0]        out_mask_reg;
    logic [7:0]        out_mask_next;
    logic [PROD_W-1:0] sum;
    logic [7:0]        gray_calc;
    logic [7:0]        gray_stored;
    logic [7:0]        gray;
    logic [7:0]        mark;

    always_comb begin
        sum = s3.prod_b + s3.prod_g + s3.prod_r + GRAY_ROUND;
        // Weights add up to one in Q14, so the shifted sum never exceeds 255.
        gray_calc = sum[PROD_W-1:GRAY_SHIFT];

        // Gray writes still held in the history registers missed this item's read; newest wins.
        gray_stored = s3.gray_old;
        for (int i = HIST_DEPTH - 1; i >= 0; i--) begin
            if (hist_reg[i].en && hist_reg[i].addr == s3.idx) begin
                gray_stored = hist_reg[i].gray;
            end
        end
        gray = s3.is_static ? gray_stored : gray_calc;

        gray_wr.en   = en && s3_valid && !cfg.use_pipeline && !s3.is_static;
        gray_wr.addr = s3.idx;
        gray_wr.gray = gray_calc;

        mark = (gray >= cfg.diff_threshold) ? MARK_ON : 8'h00;
        if (cfg.restrict_to_zone && s3.zone != cfg.selected_zone) begin
            mark = 8'h00;
        end

        if (cfg.use_pipeline) begin
            out_mask_next = s3.mask_in & ~s3.two_back;
        end else if (cfg.additive) begin
            out_mask_next = s3.mask_in | (mark & s3.zone);
        end else begin
            out_mask_next = s3.mask_in & mark;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_reg[i].en <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            hist_reg[0] <= gray_wr;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s3_valid) begin
            out_mask_reg <= out_mask_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_mask  = out_mask_reg;

endmodule

// ===== dv/motion_mask_check_pkg.sv =====
// Scoreboard for the motion mask block: per-pixel predictor and in-order mask check.
package motion_mask_check_pkg;
    import fdmm_pkg::*;

    localparam int W_BLUE      = 1868;
    localparam int W_GREEN     = 9617;
    localparam int W_RED       = 4899;
    localparam int GRAY_BIAS   = 8192;
    localparam int GRAY_FRAC   = 14;
    localparam int MAX_PRINTED = 40;

    class motion_mask_scoreboard;
        bit [23:0] prior_pixel [FRAME_PIXELS];
        bit [7:0]  gray_diff   [FRAME_PIXELS];
        bit [7:0]  mask_back1  [FRAME_PIXELS];
        bit [7:0]  mask_back2  [FRAME_PIXELS];
        cfg_t      cfg;
        bit [7:0]  expected_masks [$];
        int        noted;
        int        checked;
        int        errors;
        int        static_seen;

        function new();
            cfg         = '0;
            noted       = 0;
            checked     = 0;
            errors      = 0;
            static_seen = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] reg_idx, logic [31:0] value);
            case (reg_idx)
                REG_USE_PIPELINE:     cfg.use_pipeline     = value[0];
                REG_DIFF_THRESHOLD:   cfg.diff_threshold   = value[7:0];
                REG_RESTRICT_TO_ZONE: cfg.restrict_to_zone = value[0];
                REG_SELECTED_ZONE:    cfg.selected_zone    = value[7:0];
                REG_ADDITIVE:         cfg.additive         = value[0];
                default: ;
            endcase
        endfunction

        function bit [7:0] abs_diff(bit [7:0] a, bit [7:0] b);
            return (a >= b) ? a - b : b - a;
        endfunction

        function int pending();
            return expected_masks.size();
        endfunction

        // Predict the mask byte for one accepted pixel and advance the per-pixel history.
        function void note_pixel(pix_t p);
            bit [23:0]   old_pix;
            int unsigned gray;
            bit [7:0]    mark;
            bit [7:0]    mask_out;
            if (p.is_static) static_seen++;
            if (cfg.use_pipeline) begin
                mask_out = p.mask_in & ~mask_back2[p.idx];
                if (!p.is_static) begin
                    mask_back2[p.idx] = mask_back1[p.idx];
                    mask_back1[p.idx] = p.mask_in;
                end
            end else begin
                if (p.is_static) begin
                    gray = gray_diff[p.idx];
                end else begin
                    old_pix = prior_pixel[p.idx];
                    gray = (W_BLUE  * abs_diff(p.blue,  old_pix[7:0])
                          + W_GREEN * abs_diff(p.green, old_pix[15:8])
                          + W_RED   * abs_diff(p.red,   old_pix[23:16])
                          + GRAY_BIAS) >> GRAY_FRAC;
                    if (gray > 255) gray = 255;
                    gray_diff[p.idx]   = gray[7:0];
                    prior_pixel[p.idx] = {p.red, p.green, p.blue};
                end
                mark = (gray >= cfg.diff_threshold) ? 8'hFF : 8'h00;
                if (cfg.restrict_to_zone && p.zone != cfg.selected_zone) mark = 8'h00;
                mask_out = cfg.additive ? (p.mask_in | (mark & p.zone)) : (p.mask_in & mark);
            end
            expected_masks.push_back(mask_out);
            noted++;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("ERROR: %s", msg);
        endtask

        task check_mask(bit [7:0] got);
            bit [7:0] want;
            checked++;
            if (expected_masks.size() == 0) begin
                report_mismatch($sformatf("mask_out %02h arrived with no pixel pending", got));
                return;
            end
            want = expected_masks.pop_front();
            if (got !== want)
                report_mismatch($sformatf("result %0d: mask_out %02h, expected %02h",
                                          checked, got, want));
        endtask
    endclass

endpackage

// ===== dv/tb_top.sv =====
// Testbench top: drives pixels and register writes into the motion mask block and checks results.
module tb_top;
    import fdmm_pkg::*;
    import motion_mask_check_pkg::*;

    localparam int RANDOM_PIXELS = 1400;
    localparam int PHASES        = 10;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_SPACING  = 700;
    localparam int MAX_GAP       = 18;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [55:0]        s_tdata  = '0;
    logic [0:0]         s_tuser  = '0;
    logic               m_tready = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic               s_tready;
    logic               m_tvalid;
    logic [7:0]         m_tdata;
    logic [31:0]        prdata;
    logic               pready;

    motion_mask_scoreboard mask_sb = new();
    bit sender_burst   = 1'b0;
    bit receiver_burst = 1'b0;
    int sent           = 0;
    int holds          = 0;

    frame_difference_motion_mask dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #(CYCLE_LIMIT * 10);
        $display("Some tests failed");
        $finish;
    end

    // Leave the bus selected after the access; the caller ends the transfer sequence.
    task automatic write_reg(logic [CFG_IDX_W-1:0] reg_idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        mask_sb.apply_reg(reg_idx, value);
    endtask

    task automatic load_config(cfg_t c);
        write_reg(REG_USE_PIPELINE,     32'(c.use_pipeline));
        write_reg(REG_DIFF_THRESHOLD,   32'(c.diff_threshold));
        write_reg(REG_RESTRICT_TO_ZONE, 32'(c.restrict_to_zone));
        write_reg(REG_SELECTED_ZONE,    32'(c.selected_zone));
        write_reg(REG_ADDITIVE,         32'(c.additive));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid and wait until every predicted mask byte has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (mask_sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic send_pixel(pix_t p);
        int gap;
        if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.zone, p.mask_in, p.red, p.green, p.blue, p.idx};
        s_tuser  <= p.is_static;
        do @(posedge aclk); while (!s_tready);
        mask_sb.note_pixel(p);
        sent++;
    endtask

    function automatic pix_t make_pixel(bit [15:0] idx, bit [7:0] b, g, r, m, z, bit st);
        pix_t p;
        p.idx       = idx;
        p.blue      = b;
        p.green     = g;
        p.red       = r;
        p.mask_in   = m;
        p.zone      = z;
        p.is_static = st;
        return p;
    endfunction

    // Move a channel value by a bounded random step, clipped to 8 bits.
    function automatic bit [7:0] nudge(bit [7:0] v, int spread);
        int t;
        t = int'(v) + int'($urandom_range(0, 2 * spread)) - spread;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return t[7:0];
    endfunction

    function automatic bit [7:0] pick_mask();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'(~$urandom_range(0, 255) | $urandom_range(0, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin : result_sink
        int stall;
        int next_hold;
        next_hold = 400;
        @(posedge aclk);
        forever begin
            if (mask_sb.checked >= next_hold) begin
                // Long hold-off while the sender keeps offering pixels.
                stall = HOLD_CYCLES;
                next_hold += HOLD_SPACING;
                holds++;
            end else begin
                if ($urandom_range(0, 31) == 0) receiver_burst = !receiver_burst;
                stall = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            mask_sb.check_mask(m_tdata);
        end
    end

    initial begin : pixel_source
        cfg_t      cur;
        int        quota;
        int        phase_sent;
        int        n;
        int        frames;
        bit [15:0] base;
        bit        st;
        bit [7:0]  mk;
        bit [7:0]  cb [16];
        bit [7:0]  cg [16];
        bit [7:0]  cr [16];
        bit [7:0]  zk [16];

        quota = RANDOM_PIXELS / PHASES;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: cur = '{use_pipeline: 1'b0, diff_threshold: 8'h30, restrict_to_zone: 1'b0,
                           selected_zone: 8'h00, additive: 1'b0};
                1: cur = '{use_pipeline: 1'b1, diff_threshold: 8'hFF, restrict_to_zone: 1'b1,
                           selected_zone: 8'hFF, additive: 1'b1};
                2: cur = '{use_pipeline: 1'b0, diff_threshold: 8'h00, restrict_to_zone: 1'b1,
                           selected_zone: 8'hFF, additive: 1'b1};
                3: cur = '{use_pipeline: 1'b0, diff_threshold: 8'hFF, restrict_to_zone: 1'b0,
                           selected_zone: 8'h00, additive: 1'b1};
                default: begin
                    cur.use_pipeline     = 1'($urandom_range(0, 1));
                    cur.diff_threshold   = ($urandom_range(0, 3) == 0) ?
                                           8'($urandom_range(0, 255)) : 8'($urandom_range(0, 60));
                    cur.restrict_to_zone = 1'($urandom_range(0, 1));
                    cur.selected_zone    = 8'($urandom);
                    cur.additive         = 1'($urandom_range(0, 1));
                end
            endcase
            if (phase > 0) settle();
            load_config(cur);

            case (phase)
                0: begin
                    // Full-scale change, no change, static reuse, then one channel at a time.
                    send_pixel(make_pixel(16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0));
                    send_pixel(make_pixel(16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
                    send_pixel(make_pixel(16'h0000, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1));
                    send_pixel(make_pixel(16'hFFFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0));
                    send_pixel(make_pixel(16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0));
                    send_pixel(make_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b0));
                    send_pixel(make_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A, 8'h3C, 1'b0));
                    send_pixel(make_pixel(16'hFFFF, 8'h12, 8'h34, 8'h56, 8'hFF, 8'h00, 1'b1));
                end
                1: begin
                    // Mark survives two frames, then the two-back entry clears it.
                    send_pixel(make_pixel(16'h0005, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
                    send_pixel(make_pixel(16'h0005, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
                    send_pixel(make_pixel(16'h0005, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0));
                    send_pixel(make_pixel(16'h0005, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1));
                    send_pixel(make_pixel(16'h0005, 8'h00, 8'h00, 8'h00, 8'h0F, 8'h00, 1'b0));
                    send_pixel(make_pixel(16'hFFFF, 8'h00, 8'h00, 8'h00, 8'hF0, 8'hFF, 1'b0));
                    send_pixel(make_pixel(16'h0007, 8'hFF, 8'h00, 8'hFF, 8'hA5, 8'h00, 1'b1));
                end
                2: begin
                    // Zone gate passes, zone gate blocks, additive with a full mask.
                    send_pixel(make_pixel(16'h0028, 8'h10, 8'h20, 8'h30, 8'h00, 8'hFF, 1'b0));
                    send_pixel(make_pixel(16'h0029, 8'h10, 8'h20, 8'h30, 8'h30, 8'h0F, 1'b0));
                    send_pixel(make_pixel(16'h002A, 8'h10, 8'h20, 8'h30, 8'hFF, 8'hFF, 1'b0));
                    send_pixel(make_pixel(16'h0028, 8'h10, 8'h20, 8'h30, 8'h00, 8'h00, 1'b1));
                end
                default: ;
            endcase

            phase_sent = 0;
            while (phase_sent < quota) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_pixel(make_pixel(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                          8'($urandom), 8'($urandom), 1'($urandom_range(0, 1))));
                    phase_sent++;
                end else begin
                    // A small window of pixels seen over several frames.
                    n      = $urandom_range(2, 12);
                    frames = $urandom_range(2, 6);
                    case ($urandom_range(0, 3))
                        0:       base = 16'($urandom_range(0, 48));
                        1:       base = 16'(16'hFFFF - n + 1);
                        2:       base = 16'($urandom);
                        default: base = 16'd100;
                    endcase
                    for (int k = 0; k < n; k++) begin
                        cb[k] = 8'($urandom);
                        cg[k] = 8'($urandom);
                        cr[k] = 8'($urandom);
                        case ($urandom_range(0, 3))
                            0:       zk[k] = cur.selected_zone;
                            1:       zk[k] = 8'h00;
                            2:       zk[k] = 8'hFF;
                            default: zk[k] = 8'($urandom);
                        endcase
                    end
                    for (int f = 0; f < frames; f++) begin
                        st = (f > 0) && ($urandom_range(0, 4) == 0);
                        for (int k = 0; k < n; k++) begin
                            if (!st) begin
                                case ($urandom_range(0, 3))
                                    0: ;
                                    1: begin
                                        cb[k] = nudge(cb[k], 12);
                                        cg[k] = nudge(cg[k], 12);
                                        cr[k] = nudge(cr[k], 12);
                                    end
                                    2: begin
                                        cb[k] = nudge(cb[k], 60);
                                        cg[k] = nudge(cg[k], 60);
                                        cr[k] = nudge(cr[k], 60);
                                    end
                                    default: begin
                                        cb[k] = 8'($urandom);
                                        cg[k] = 8'($urandom);
                                        cr[k] = 8'($urandom);
                                    end
                                endcase
                            end
                            mk = pick_mask();
                            send_pixel(make_pixel(16'(base + k), cb[k], cg[k], cr[k], mk,
                                                  zk[k], st));
                            phase_sent++;
                        end
                    end
                end
            end
        end

        settle();
        $display("Run covered %0d pixels (%0d static) over %0d register settings, both modes",
                 sent, mask_sb.static_seen, PHASES);
        $display("%0d mask bytes compared; output held off %0d times for %0d cycles",
                 mask_sb.checked, holds, HOLD_CYCLES);
        if (mask_sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
